[src/usp_pkg.sv]
package usp_pkg;

    localparam int unsigned QueueDepthDefault = 64;
    localparam int unsigned CfgWidth = 7;
    localparam int unsigned TagWidth = 32;
    localparam int unsigned TimeWidth = 48;

    typedef enum logic [1:0] {
        MODE_PUSH    = 2'd0,
        MODE_ANALYZE = 2'd1,
        MODE_FETCH   = 2'd2,
        MODE_NOP     = 2'd3
    } mode_t;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BUF  = 2'd1;
    localparam logic [1:0] PH_POST = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_FETCH = 2'd2;

    localparam logic [2:0] CFG_PRE  = 3'd0;
    localparam logic [2:0] CFG_POST = 3'd1;
    localparam logic [2:0] CFG_ON   = 3'd2;
    localparam logic [2:0] CFG_OFF  = 3'd3;
    localparam logic [2:0] CFG_TOG  = 3'd4;

    typedef struct packed {
        logic [1:0]           mode;
        logic                 vad_active;
        logic [TagWidth-1:0]  frame_tag;
        logic [TimeWidth-1:0] frame_time;
    } cmd_t;

    typedef struct packed {
        logic [1:0]           phase;
        logic [CfgWidth-1:0]  available_count;
        logic                 nothing_available;
        logic [TagWidth-1:0]  out_frame_tag;
        logic [TimeWidth-1:0] out_frame_time;
        logic                 out_vad_active;
        logic                 out_valid;
        logic [TagWidth-1:0]  utterance_start_tag;
        logic [TimeWidth-1:0] utterance_start_time;
        logic [TagWidth-1:0]  utterance_stop_tag;
        logic [TimeWidth-1:0] utterance_stop_time;
        logic [1:0]           error;
    } res_t;

endpackage

[src/usp_front.sv]
module usp_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    mode,
    input  logic          vad_active,
    input  logic [31:0]   frame_tag,
    input  logic [47:0]   frame_time,
    output logic          q_valid,
    input  logic          q_pop,
    output usp_pkg::cmd_t q_cmd
);
    import usp_pkg::*;

    // two-entry command queue
    cmd_t q_mem_reg [2];
    logic rd_ptr_reg, rd_ptr_next;
    logic wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{mode, vad_active, frame_tag, frame_time};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

[src/usp_back.sv]
module usp_back
#(
    parameter int unsigned QUEUE_DEPTH = usp_pkg::QueueDepthDefault
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_pop,
    input  usp_pkg::cmd_t q_cmd,
    input  logic [6:0]    pre_frames,
    input  logic [6:0]    post_frames,
    input  logic [6:0]    on_frames,
    input  logic [6:0]    off_frames,
    input  logic [6:0]    max_toggles,
    output logic          res_valid,
    input  logic          res_stall,
    output usp_pkg::res_t res
);
    import usp_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    // counts also hold the 7-bit register values
    localparam int unsigned CW = (AW + 1 > 8) ? AW + 1 : 8;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SREAD  = 7'b0000010,
        S_SCHK   = 7'b0000100,
        S_SEND   = 7'b0001000,
        S_PREAD  = 7'b0010000,
        S_PCHK   = 7'b0100000,
        S_FIN    = 7'b1000000
    } st_t;

    // the scan issues one memory read per frame; phase flag for stop scan
    st_t st_reg, st_next;

    logic [TagWidth-1:0]  tag_mem [QUEUE_DEPTH];
    logic [TimeWidth-1:0] time_mem [QUEUE_DEPTH];
    logic                 flag_mem [QUEUE_DEPTH];

    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [1:0]    phase_reg;
    logic [CW-1:0] scan_pos_reg;
    logic [CW-1:0] unbuf_reg;
    logic [CW-1:0] countdown_reg;
    logic [TagWidth-1:0]  st_tag_reg, sp_tag_reg;
    logic [TimeWidth-1:0] st_time_reg, sp_time_reg;

    // scan working registers
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] act_reg, tog_reg, run_reg;
    logic          last_reg;
    logic          stop_mode_reg;
    logic [CW-1:0] start_reg, at_reg;
    logic          found_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [TagWidth-1:0]  rd_tag;
    logic [TimeWidth-1:0] rd_time;
    logic          rd_flag;

    logic          out_full_reg;
    res_t          res_reg;

    assign res_valid = out_full_reg;
    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_tag  <= tag_mem[rd_addr];
            rd_time <= time_mem[rd_addr];
            rd_flag <= flag_mem[rd_addr];
        end
    end

    function automatic logic [AW-1:0] slot_of(logic [AW-1:0] h, logic [CW-1:0] k);
        logic [CW-1:0] s;
        s = CW'(h) + k;
        if (s >= DEPTH_C)
            s = s - DEPTH_C;
        return s[AW-1:0];
    endfunction

    function automatic logic [CW-1:0] avail_f(logic [1:0] ph, logic [CW-1:0] cnt,
                                              logic [CW-1:0] ub, logic [CW-1:0] cd,
                                              logic [6:0] pf);
        logic [CW+7:0] a;
        logic [CW+7:0] lim;
        logic [CW+7:0] nx;
        logic [CW-1:0] r;
        a = '0; lim = '0; nx = '0; r = '0;
        if (ph == PH_BUF)
        begin
            r = cnt;
        end
        else if (ph == PH_POST)
        begin
            if (ub != '0)
            begin
                a = (CW+8)'(ub) + (CW+8)'(pf);
                r = (a < (CW+8)'(cnt)) ? a[CW-1:0] : cnt;
            end
            else if ((CW+8)'(cd) <= (CW+8)'(pf))
            begin
                nx = (CW+8)'(pf) - (CW+8)'(cd);
                lim = ((CW+8)'(cnt) < (CW+8)'(pf)) ? (CW+8)'(cnt) : (CW+8)'(pf);
                r = (nx >= lim) ? '0 : CW'(lim - nx);
            end
        end
        return r;
    endfunction

    logic is_push, is_ana, is_fetch;
    logic [CW-1:0] av_now;
    logic [CW+7:0] ptr_off;
    logic [CW-1:0] tog_n, act_n, run_n, start_n, chop;
    logic          hit_on, hit_tog, f;
    logic          out_free;

    assign is_push  = q_cmd.mode == MODE_PUSH;
    assign is_ana   = q_cmd.mode == MODE_ANALYZE;
    assign is_fetch = q_cmd.mode == MODE_FETCH;
    assign av_now   = avail_f(phase_reg, count_reg, unbuf_reg, countdown_reg, post_frames);
    assign out_free = !out_full_reg || !res_stall;
    assign f = rd_flag;

    always_comb
    begin
        tog_n = tog_reg + ((f != last_reg) ? CW'(1) : CW'(0));
        act_n = act_reg;
        if (f)
            act_n = act_reg + CW'(1);
        else if (act_reg != '0)
            act_n = act_reg - CW'(1);
        else
            tog_n = '0;
        hit_on  = act_n >= CW'(on_frames);
        hit_tog = (act_n != '0) && ((CW+1)'(tog_n) > (CW+1)'(max_toggles));
        start_n = '0;
        if (hit_on)
            start_n = (idx_reg >= CW'(on_frames)) ? idx_reg - CW'(on_frames) : '0;
        else if ((CW+1)'(idx_reg) >= (CW+1)'(max_toggles))
            start_n = idx_reg - CW'(max_toggles);
        run_n = f ? '0 : run_reg + CW'(1);
        chop = '0;
        if (found_reg)
        begin
            if ((CW+1)'(start_reg) > (CW+1)'(pre_frames))
                chop = start_reg - CW'(pre_frames) + CW'(1);
        end
        else if ((CW+1)'(count_reg) > (CW+1)'(pre_frames))
        begin
            chop = count_reg - CW'(pre_frames);
        end
        ptr_off = (CW+8)'(post_frames) - (CW+8)'(countdown_reg);
    end

    always_comb
    begin
        st_next = st_reg;
        q_pop = 1'b0;
        rd_en = 1'b0;
        rd_addr = slot_of(head_reg, idx_reg);
        unique case (st_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (is_ana && phase_reg == PH_IDLE)
                        st_next = (count_reg == '0) ? S_SEND : S_SREAD;
                    else if (is_ana && phase_reg == PH_BUF)
                        st_next = S_PREAD;
                    else if (is_fetch && av_now != '0)
                    begin
                        rd_en = 1'b1;
                        rd_addr = (phase_reg == PH_BUF || unbuf_reg != '0) ? head_reg
                                  : slot_of(head_reg, ptr_off[CW-1:0]);
                        st_next = S_FIN;
                    end
                    else
                        st_next = S_FIN;
                end
            end
            S_SREAD:
            begin
                rd_en = 1'b1;
                st_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (hit_on || hit_tog || idx_reg + CW'(1) >= count_reg)
                    st_next = S_SEND;
                else
                    st_next = S_SREAD;
            end
            S_SEND:
            begin
                if (found_reg)
                begin
                    rd_en = 1'b1;
                    rd_addr = slot_of(head_reg, start_reg);
                    st_next = S_PREAD;
                end
                else
                    st_next = S_FIN;
            end
            S_PREAD:
            begin
                if (stop_mode_reg && idx_reg < count_reg)
                begin
                    rd_en = 1'b1;
                    st_next = S_PCHK;
                end
                else if (stop_mode_reg)
                    st_next = S_FIN;
                else
                    st_next = S_PREAD;
            end
            S_PCHK:
            begin
                if (run_n >= CW'(off_frames))
                begin
                    rd_en = 1'b1;
                    st_next = S_FIN;
                end
                else
                    st_next = S_PREAD;
            end
            S_FIN:
                st_next = S_IDLE;
            default:
                st_next = S_IDLE;
        endcase
    end

    // stop-scan hit is remembered so FIN captures the stop frame
    logic stop_hit_reg;
    logic [1:0] err_reg;
    logic fetch_out_reg;

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && q_valid && out_free && is_push && count_reg < DEPTH_C)
        begin
            tag_mem[slot_of(head_reg, count_reg)]  <= q_cmd.frame_tag;
            time_mem[slot_of(head_reg, count_reg)] <= q_cmd.frame_time;
            flag_mem[slot_of(head_reg, count_reg)] <= q_cmd.vad_active;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            head_reg <= '0;
            count_reg <= '0;
            phase_reg <= PH_IDLE;
            scan_pos_reg <= '0;
            unbuf_reg <= '0;
            countdown_reg <= '0;
            st_tag_reg <= '0;
            st_time_reg <= '0;
            sp_tag_reg <= '0;
            sp_time_reg <= '0;
            idx_reg <= '0;
            act_reg <= '0;
            tog_reg <= '0;
            run_reg <= '0;
            last_reg <= 1'b0;
            stop_mode_reg <= 1'b0;
            start_reg <= '0;
            at_reg <= '0;
            found_reg <= 1'b0;
            stop_hit_reg <= 1'b0;
            err_reg <= ERR_NONE;
            fetch_out_reg <= 1'b0;
            out_full_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_full_reg && !res_stall)
                out_full_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_valid && out_free)
                    begin
                        stop_hit_reg <= 1'b0;
                        act_reg <= '0;
                        tog_reg <= '0;
                        last_reg <= 1'b0;
                        found_reg <= 1'b0;
                        run_reg <= '0;
                        stop_mode_reg <= is_ana && (phase_reg == PH_BUF);
                        idx_reg <= (is_ana && phase_reg == PH_BUF) ? scan_pos_reg : '0;
                        fetch_out_reg <= is_fetch && (av_now != '0);
                        if (is_push && count_reg >= DEPTH_C)
                            err_reg <= ERR_FULL;
                        else if (is_fetch && av_now == '0)
                            err_reg <= ERR_FETCH;
                        else
                            err_reg <= ERR_NONE;
                        if (is_push)
                        begin
                            if (count_reg < DEPTH_C)
                                count_reg <= count_reg + CW'(1);
                        end
                        else if (is_fetch)
                        begin
                            if (av_now == '0)
                            begin
                                if (phase_reg == PH_POST && unbuf_reg == '0
                                    && countdown_reg == '0)
                                    phase_reg <= PH_IDLE;
                            end
                            else if (phase_reg == PH_BUF || unbuf_reg != '0)
                            begin
                                head_reg <= slot_of(head_reg, CW'(1));
                                count_reg <= count_reg - CW'(1);
                                if (phase_reg == PH_POST)
                                    unbuf_reg <= unbuf_reg - CW'(1);
                            end
                            else
                            begin
                                countdown_reg <= countdown_reg - CW'(1);
                                if (countdown_reg == CW'(1))
                                    phase_reg <= PH_IDLE;
                            end
                        end
                    end
                end
                S_SCHK:
                begin
                    act_reg <= act_n;
                    tog_reg <= tog_n;
                    last_reg <= f;
                    if (hit_on || hit_tog)
                    begin
                        found_reg <= 1'b1;
                        start_reg <= start_n;
                        at_reg <= idx_reg;
                    end
                    else
                        idx_reg <= idx_reg + CW'(1);
                end
                S_SEND:
                begin
                    head_reg <= slot_of(head_reg, chop);
                    count_reg <= count_reg - chop;
                    if (found_reg)
                    begin
                        phase_reg <= PH_BUF;
                        idx_reg <= (at_reg >= chop) ? at_reg - chop : '0;
                        scan_pos_reg <= (at_reg >= chop) ? at_reg - chop : '0;
                    end
                end
                S_PREAD:
                begin
                    if (!stop_mode_reg)
                    begin
                        // start frame read issued in SEND
                        st_tag_reg <= rd_tag;
                        st_time_reg <= rd_time;
                        stop_mode_reg <= 1'b1;
                    end
                    else if (idx_reg >= count_reg)
                        scan_pos_reg <= count_reg;
                end
                S_PCHK:
                begin
                    run_reg <= run_n;
                    if (run_n >= CW'(off_frames))
                    begin
                        stop_hit_reg <= 1'b1;
                        phase_reg <= PH_POST;
                        unbuf_reg <= idx_reg + CW'(1);
                        countdown_reg <= CW'(post_frames);
                    end
                    else
                        idx_reg <= idx_reg + CW'(1);
                end
                S_FIN:
                begin
                    if (stop_hit_reg)
                    begin
                        sp_tag_reg <= rd_tag;
                        sp_time_reg <= rd_time;
                    end
                    out_full_reg <= 1'b1;
                    res_reg.phase <= phase_reg;
                    res_reg.available_count <= 7'(av_now);
                    res_reg.nothing_available <= (7'(av_now) == 7'd0);
                    res_reg.out_frame_tag <= fetch_out_reg ? rd_tag : '0;
                    res_reg.out_frame_time <= fetch_out_reg ? rd_time : '0;
                    res_reg.out_vad_active <= fetch_out_reg ? rd_flag : 1'b0;
                    res_reg.out_valid <= fetch_out_reg;
                    res_reg.utterance_start_tag <= st_tag_reg;
                    res_reg.utterance_start_time <= st_time_reg;
                    res_reg.utterance_stop_tag <= stop_hit_reg ? rd_tag : sp_tag_reg;
                    res_reg.utterance_stop_time <= stop_hit_reg ? rd_time : sp_time_reg;
                    res_reg.error <= err_reg;
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

[src/utterance_segmenter_pre_post_buffer_core.sv]
// Push, fetch and no-op commands go from IDLE to FIN, which registers the result;
// analyze scans frame by frame: a start scan from idle phase, then a stop scan once
// a start is found or when buffering, with one queue memory read per frame scanned.
// One item at a time in the back end; a 2-entry command queue
// lets the input side run ahead. Reset (rst_n low, asynchronous) empties the
// queue, sets idle phase and loads the register defaults; queue memory is not cleared.
module utterance_segmenter_pre_post_buffer_core
#(
    parameter int unsigned QUEUE_DEPTH = usp_pkg::QueueDepthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic        vad_active,
    input  logic [31:0] frame_tag,
    input  logic [47:0] frame_time,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  phase,
    output logic [6:0]  available_count,
    output logic        nothing_available,
    output logic [31:0] out_frame_tag,
    output logic [47:0] out_frame_time,
    output logic        out_vad_active,
    output logic        out_valid,
    output logic [31:0] utterance_start_tag,
    output logic [47:0] utterance_start_time,
    output logic [31:0] utterance_stop_tag,
    output logic [47:0] utterance_stop_time,
    output logic [1:0]  error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import usp_pkg::*;

    logic [6:0] pre_reg, post_reg, on_reg, off_reg, tog_reg;
    logic q_valid, q_pop;
    cmd_t q_cmd;
    res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg <= 7'd10;
            post_reg <= 7'd10;
            on_reg <= 7'd5;
            off_reg <= 7'd10;
            tog_reg <= 7'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PRE:  pre_reg <= cfg_data;
                CFG_POST: post_reg <= cfg_data;
                CFG_ON:   on_reg <= cfg_data;
                CFG_OFF:  off_reg <= cfg_data;
                CFG_TOG:  tog_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    usp_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .vad_active(vad_active), .frame_tag(frame_tag),
        .frame_time(frame_time), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
    );

    usp_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .pre_frames(pre_reg), .post_frames(post_reg), .on_frames(on_reg),
        .off_frames(off_reg), .max_toggles(tog_reg),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    assign phase = res.phase;
    assign available_count = res.available_count;
    assign nothing_available = res.nothing_available;
    assign out_frame_tag = res.out_frame_tag;
    assign out_frame_time = res.out_frame_time;
    assign out_vad_active = res.out_vad_active;
    assign out_valid = res.out_valid;
    assign utterance_start_tag = res.utterance_start_tag;
    assign utterance_start_time = res.utterance_start_time;
    assign utterance_stop_tag = res.utterance_stop_tag;
    assign utterance_stop_time = res.utterance_stop_time;
    assign error = res.error;

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (phase != 2'd3))
        else $error("illegal phase");
    a_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (nothing_available == (available_count == 7'd0)))
        else $error("nothing_available mismatch");
    a_outvalid_err: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid) |-> (error == ERR_NONE))
        else $error("frame delivered with error");
endmodule
